// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the selector modules. Each form
// samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CAPS_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CAPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CAPS_ASSERT_IMPLY(name, ante, cons, msg)

`define CAPS_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- hdl/caps_pkg.sv -----
// ----------------------------------------------------------------------------
// Selector package
// Types, widths, reset values and register codes of the adaptive-pursuit
// crossover operator selector.
// ----------------------------------------------------------------------------
package caps_pkg;

    localparam int NUM_OPERATORS = 3;
    localparam int OP_W          = $clog2(NUM_OPERATORS);
    localparam int CNT_W         = $clog2(NUM_OPERATORS + 1);

    localparam int PROB_W     = 17;
    localparam int QUAL_W     = 24;
    localparam int COUNT_W    = 32;
    localparam int RATE_W     = 17;
    localparam int FLOOR_W    = 15;
    localparam int FRAC_W     = 16;
    localparam int MAKESPAN_W = 32;
    localparam int SUM_W      = MAKESPAN_W + 1;
    localparam int CUM_W      = PROB_W + OP_W;
    localparam int TAKEN_W    = PROB_W + OP_W;

    localparam int REWARD_W      = 24;
    localparam int REWARD_FRAC_W = 16;
    localparam int SAT_SHIFT     = REWARD_W - REWARD_FRAC_W;
    localparam int DIV_STEPS     = REWARD_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int BLEND_SHIFT   = 16;

    localparam logic [PROB_W-1:0]   ONE_Q16     = 17'd65536;
    localparam logic [REWARD_W-1:0] REWARD_MAX  = 24'hFFFFFF;
    localparam logic [PROB_W-1:0]   PROB_RESET  = 17'd21845;
    localparam logic [QUAL_W-1:0]   QUAL_RESET  = 24'd65536;
    localparam logic [RATE_W-1:0]   QRATE_RESET = 17'd52429;
    localparam logic [RATE_W-1:0]   PRATE_RESET = 17'd52429;
    localparam logic [FLOOR_W-1:0]  FLOOR_RESET = 15'd9830;
    localparam logic [FLOOR_W-1:0]  FLOOR_MAX   = 15'd21845;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATE_W;
    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PURSUIT_RATE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROBABILITY_FLOOR = 2'd2;

    localparam logic FUNC_SELECT = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [FRAC_W-1:0]     random_fraction;
        logic [MAKESPAN_W-1:0] parent_a_makespan;
        logic [MAKESPAN_W-1:0] parent_b_makespan;
        logic [MAKESPAN_W-1:0] child_a_makespan;
        logic [MAKESPAN_W-1:0] child_b_makespan;
    } item_t;

    typedef struct packed {
        logic [1:0] chosen_operator;
        logic       was_selection;
        logic [1:0] best_operator;
    } result_t;

    typedef struct packed {
        logic              valid;
        logic [QUAL_W-1:0] old_value;
        logic [QUAL_W-1:0] new_value;
        logic [RATE_W-1:0] weight;
    } blend_req_t;

    typedef struct packed {
        logic              valid;
        logic [QUAL_W-1:0] value;
    } blend_rsp_t;

    // Equal share of the full probability among the operators not yet used.
    function automatic logic [PROB_W-1:0] warm_share(input logic [CNT_W-1:0] unused);
        logic [3:0]        k;
        logic [PROB_W-1:0] share;
        k = 4'(unused);
        case (k)
            4'd1:    share = 17'd65536;
            4'd2:    share = 17'd32768;
            4'd3:    share = 17'd21845;
            4'd4:    share = 17'd16384;
            4'd5:    share = 17'd13107;
            4'd6:    share = 17'd10922;
            4'd7:    share = 17'd9362;
            4'd8:    share = 17'd8192;
            default: share = '0;
        endcase
        return share;
    endfunction

endpackage

// ----- hdl/crossover_adaptive_pursuit_selector_top.sv -----
// ----------------------------------------------------------------------------
// Adaptive-pursuit crossover operator selector
// Keeps probability, quality and use counts for each crossover operator,
// picks an operator on select items and applies reward updates.
// ----------------------------------------------------------------------------
// A select item passes through the select and finish steps to a waiting
// result. An update item runs the 24-step reward divider, which a saturating
// reward skips, then the two-stage blend unit once per credited operator and,
// after warm-up, once per operator for the pursuit step. Only one item is in
// work at a time, but a new item is taken while the last result waits in the
// output register.
module crossover_adaptive_pursuit_selector_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [caps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [caps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  caps_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output caps_pkg::result_t                   result
);

    localparam int N = caps_pkg::NUM_OPERATORS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEL    = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_CREDIT = 3'd3;
    localparam logic [2:0] S_CWAIT  = 3'd4;
    localparam logic [2:0] S_PROB   = 3'd5;
    localparam logic [2:0] S_PWAIT  = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]                         state_reg, state_next;
    logic [caps_pkg::OP_W-1:0]          idx_reg, idx_next;
    logic [caps_pkg::OP_W-1:0]          op_reg, op_next;
    logic                               func_reg, func_next;
    logic [caps_pkg::FRAC_W-1:0]        frac_reg, frac_next;
    logic [caps_pkg::REWARD_W-1:0]      reward_reg, reward_next;
    logic [caps_pkg::RATE_W-1:0]        qrate_reg, qrate_next;
    logic [caps_pkg::RATE_W-1:0]        prate_reg, prate_next;
    logic [caps_pkg::FLOOR_W-1:0]       floor_reg, floor_next;
    logic [caps_pkg::PROB_W-1:0]        prob_reg [N];
    logic [caps_pkg::PROB_W-1:0]        prob_next [N];
    logic [caps_pkg::QUAL_W-1:0]        qual_reg [N];
    logic [caps_pkg::QUAL_W-1:0]        qual_next [N];
    logic [caps_pkg::COUNT_W-1:0]       use_reg [N];
    logic [caps_pkg::COUNT_W-1:0]       use_next [N];
    logic [caps_pkg::COUNT_W-1:0]       rew_reg [N];
    logic [caps_pkg::COUNT_W-1:0]       rew_next [N];
    logic                               result_valid_reg, result_valid_next;
    caps_pkg::result_t                  result_reg, result_next;

    logic [caps_pkg::RATE_W-1:0]        alpha;
    logic [caps_pkg::RATE_W-1:0]        beta;
    logic [caps_pkg::FLOOR_W-1:0]       pmin;
    logic [caps_pkg::TAKEN_W-1:0]       taken;
    logic [caps_pkg::PROB_W-1:0]        pmax;
    logic [caps_pkg::PROB_W-1:0]        target;
    logic [caps_pkg::CNT_W-1:0]         used_cnt;
    logic [caps_pkg::CNT_W-1:0]         unused_cnt;
    logic                               warm;
    logic                               credit_now;
    logic                               last_op;
    logic [caps_pkg::OP_W-1:0]          best;
    logic [caps_pkg::OP_W-1:0]          chosen;
    logic [caps_pkg::CUM_W-1:0]         cum;
    logic                               found;
    logic                               accept;
    logic [caps_pkg::SUM_W-1:0]         parent_sum;
    logic [caps_pkg::SUM_W-1:0]         child_sum;
    logic                               div_start;
    logic                               div_done;
    logic [caps_pkg::REWARD_W-1:0]      div_quotient;
    caps_pkg::blend_req_t               blend_req;
    caps_pkg::blend_rsp_t               blend_rsp;

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign parent_sum = caps_pkg::SUM_W'(item.parent_a_makespan)
                      + caps_pkg::SUM_W'(item.parent_b_makespan);
    assign child_sum  = caps_pkg::SUM_W'(item.child_a_makespan)
                      + caps_pkg::SUM_W'(item.child_b_makespan);
    assign div_start  = accept && (item.func == caps_pkg::FUNC_UPDATE);

    caps_div u_div
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_sum (parent_sum),
        .divisor_sum  (child_sum),
        .done         (div_done),
        .quotient     (div_quotient)
    );

    caps_blend u_blend
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (blend_req),
        .rsp   (blend_rsp)
    );

    // Rates and floor beyond their meaningful range act as their maximum.
    always_comb
    begin
        alpha = (qrate_reg > caps_pkg::ONE_Q16) ? caps_pkg::ONE_Q16 : qrate_reg;
        beta  = (prate_reg > caps_pkg::ONE_Q16) ? caps_pkg::ONE_Q16 : prate_reg;
        pmin  = (floor_reg > caps_pkg::FLOOR_MAX) ? caps_pkg::FLOOR_MAX : floor_reg;
        taken = caps_pkg::TAKEN_W'(pmin) * caps_pkg::TAKEN_W'(N - 1);
        if (taken >= caps_pkg::TAKEN_W'(caps_pkg::ONE_Q16))
        begin
            pmax = '0;
        end
        else
        begin
            pmax = caps_pkg::PROB_W'(caps_pkg::TAKEN_W'(caps_pkg::ONE_Q16) - taken);
        end
    end

    always_comb
    begin
        used_cnt = '0;
        best     = '0;
        for (int i = 0; i < N; i++)
        begin
            if (use_reg[i] != '0)
            begin
                used_cnt = used_cnt + 1'b1;
            end
        end
        for (int i = 1; i < N; i++)
        begin
            if (qual_reg[best] < qual_reg[i])
            begin
                best = caps_pkg::OP_W'(i);
            end
        end
        unused_cnt = caps_pkg::CNT_W'(N) - used_cnt;
        warm       = used_cnt < caps_pkg::CNT_W'(N);
    end

    always_comb
    begin
        cum    = '0;
        found  = 1'b0;
        chosen = caps_pkg::OP_W'(N - 1);
        for (int i = 0; i < N - 1; i++)
        begin
            cum = cum + caps_pkg::CUM_W'(prob_reg[i]);
            if (!found && (caps_pkg::CUM_W'(frac_reg) < cum))
            begin
                chosen = caps_pkg::OP_W'(i);
                found  = 1'b1;
            end
        end
    end

    always_comb
    begin
        last_op = (idx_reg == caps_pkg::OP_W'(N - 1));
        target  = (idx_reg == best) ? pmax : caps_pkg::PROB_W'(pmin);
        if (warm)
        begin
            credit_now = (use_reg[idx_reg] == caps_pkg::COUNT_W'(1))
                      && (rew_reg[idx_reg] != caps_pkg::COUNT_W'(1));
        end
        else
        begin
            credit_now = rew_reg[idx_reg] < use_reg[idx_reg];
        end

        blend_req.valid     = 1'b0;
        blend_req.old_value = qual_reg[idx_reg];
        blend_req.new_value = reward_reg;
        blend_req.weight    = alpha;
        if (state_reg == S_PROB)
        begin
            blend_req.valid     = 1'b1;
            blend_req.old_value = caps_pkg::QUAL_W'(prob_reg[idx_reg]);
            blend_req.new_value = caps_pkg::QUAL_W'(target);
            blend_req.weight    = beta;
        end
        else if (state_reg == S_CREDIT)
        begin
            blend_req.valid = credit_now;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        op_next           = op_reg;
        func_next         = func_reg;
        frac_next         = frac_reg;
        reward_next       = reward_reg;
        qrate_next        = qrate_reg;
        prate_next        = prate_reg;
        floor_next        = floor_reg;
        prob_next         = prob_reg;
        qual_next         = qual_reg;
        use_next          = use_reg;
        rew_next          = rew_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            case (cfg_index)
                caps_pkg::REG_QUALITY_RATE:      qrate_next = cfg_data;
                caps_pkg::REG_PURSUIT_RATE:      prate_next = cfg_data;
                caps_pkg::REG_PROBABILITY_FLOOR: floor_next = cfg_data[caps_pkg::FLOOR_W-1:0];
                default:                         qrate_next = qrate_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = item.func;
                    frac_next = item.random_fraction;
                    idx_next  = '0;
                    state_next = (item.func == caps_pkg::FUNC_UPDATE) ? S_DIV : S_SEL;
                end
            end
            S_SEL:
            begin
                op_next = chosen;
                use_next[chosen] = use_reg[chosen] + 1'b1;
                state_next = S_FIN;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    reward_next = div_quotient;
                    if (warm)
                    begin
                        for (int i = 0; i < N; i++)
                        begin
                            if ((use_reg[i] == caps_pkg::COUNT_W'(1))
                                && (rew_reg[i] != caps_pkg::COUNT_W'(1)))
                            begin
                                prob_next[i] = '0;
                            end
                            else if (use_reg[i] == '0)
                            begin
                                prob_next[i] = caps_pkg::warm_share(unused_cnt);
                            end
                        end
                    end
                    state_next = S_CREDIT;
                end
            end
            S_CREDIT:
            begin
                if (credit_now)
                begin
                    rew_next[idx_reg] = use_reg[idx_reg];
                    state_next = S_CWAIT;
                end
                else if (last_op)
                begin
                    idx_next   = '0;
                    state_next = warm ? S_FIN : S_PROB;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_CWAIT:
            begin
                if (blend_rsp.valid)
                begin
                    qual_next[idx_reg] = blend_rsp.value;
                    if (last_op)
                    begin
                        idx_next   = '0;
                        state_next = warm ? S_FIN : S_PROB;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_CREDIT;
                    end
                end
            end
            S_PROB:
            begin
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                if (blend_rsp.valid)
                begin
                    prob_next[idx_reg] = blend_rsp.value[caps_pkg::PROB_W-1:0];
                    if (last_op)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_PROB;
                    end
                end
            end
            S_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.was_selection   = (func_reg == caps_pkg::FUNC_SELECT);
                    result_next.chosen_operator = (func_reg == caps_pkg::FUNC_SELECT)
                                                ? 2'(op_reg) : 2'b00;
                    result_next.best_operator   = 2'(best);
                    result_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
            qrate_reg        <= caps_pkg::QRATE_RESET;
            prate_reg        <= caps_pkg::PRATE_RESET;
            floor_reg        <= caps_pkg::FLOOR_RESET;
            for (int i = 0; i < N; i++)
            begin
                prob_reg[i] <= caps_pkg::PROB_RESET;
                qual_reg[i] <= caps_pkg::QUAL_RESET;
                use_reg[i]  <= '0;
                rew_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
            qrate_reg        <= qrate_next;
            prate_reg        <= prate_next;
            floor_reg        <= floor_next;
            prob_reg         <= prob_next;
            qual_reg         <= qual_next;
            use_reg          <= use_next;
            rew_reg          <= rew_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        func_reg   <= func_next;
        frac_reg   <= frac_next;
        reward_reg <= reward_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "assert_macros.svh"

    `CAPS_ASSERT_IMPLY(a_div_done_in_div, div_done, state_reg == S_DIV, "reward ready outside the divide step")
    `CAPS_ASSERT_IMPLY(a_blend_in_wait, blend_rsp.valid, state_reg == S_CWAIT || state_reg == S_PWAIT, "blend result arrived unexpectedly")
    `CAPS_ASSERT_NEXT(a_sel_to_fin, state_reg == S_SEL, state_reg == S_FIN, "select did not finish in one cycle")
    `CAPS_ASSERT_IMPLY(a_result_from_fin, $rose(result_valid_reg), $past(state_reg) == S_FIN, "result loaded outside the finish step")

endmodule

// ----- hdl/caps_div.sv -----
// ----------------------------------------------------------------------------
// Reward divider
// Restoring divider forming (parent sum * 2^16) / (child sum), one quotient
// bit per cycle, saturated to the reward maximum.
// ----------------------------------------------------------------------------
module caps_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [caps_pkg::SUM_W-1:0]      dividend_sum,
    input  logic [caps_pkg::SUM_W-1:0]      divisor_sum,
    output logic                            done,
    output logic [caps_pkg::REWARD_W-1:0]   quotient
);

    localparam int WIDE_W = caps_pkg::SUM_W + caps_pkg::SAT_SHIFT;

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [caps_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [caps_pkg::SUM_W-1:0]         rem_reg, rem_next;
    logic [caps_pkg::SUM_W-1:0]         divisor_reg, divisor_next;
    logic [caps_pkg::DIV_STEPS-1:0]     low_reg, low_next;
    logic [caps_pkg::REWARD_W-1:0]      quo_reg, quo_next;

    logic [WIDE_W-1:0]                  wide_p;
    logic [WIDE_W-1:0]                  wide_c;
    logic                               saturate;
    logic [caps_pkg::SUM_W:0]           shifted;
    logic [caps_pkg::SUM_W:0]           trial;
    logic                               fits;

    assign wide_p   = WIDE_W'(dividend_sum);
    assign wide_c   = {divisor_sum, {caps_pkg::SAT_SHIFT{1'b0}}};
    assign saturate = (divisor_sum == '0) || (wide_p >= wide_c);
    assign shifted  = {rem_reg, low_reg[caps_pkg::DIV_STEPS-1]};
    assign trial    = shifted - {1'b0, divisor_reg};
    assign fits     = shifted >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        low_next     = low_reg;
        quo_next     = quo_reg;
        if (start)
        begin
            divisor_next = divisor_sum;
            rem_next     = caps_pkg::SUM_W'(dividend_sum >> caps_pkg::SAT_SHIFT);
            low_next     = {dividend_sum[caps_pkg::SAT_SHIFT-1:0],
                            {caps_pkg::REWARD_FRAC_W{1'b0}}};
            cnt_next     = caps_pkg::DIV_CNT_W'(caps_pkg::DIV_STEPS);
            if (saturate)
            begin
                quo_next  = caps_pkg::REWARD_MAX;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[caps_pkg::SUM_W-1:0] : shifted[caps_pkg::SUM_W-1:0];
            low_next = {low_reg[caps_pkg::DIV_STEPS-2:0], 1'b0};
            quo_next = {quo_reg[caps_pkg::REWARD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == caps_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        low_reg     <= low_next;
        quo_reg     <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`include "assert_macros.svh"

    `CAPS_ASSERT_IMPLY(a_busy_has_steps, busy_reg, cnt_reg != '0, "divider busy with no steps left")
    `CAPS_ASSERT_IMPLY(a_start_when_free, start, !busy_reg && !done_reg, "divider restarted while working")

endmodule

// ----- hdl/caps_blend.sv -----
// ----------------------------------------------------------------------------
// Blend unit
// Two-stage unit computing old + round(weight * (new - old) / 2^16), the
// shared arithmetic for quality and probability updates.
// ----------------------------------------------------------------------------
module caps_blend
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  caps_pkg::blend_req_t    req,
    output caps_pkg::blend_rsp_t    rsp
);

    localparam int DIFF_W = caps_pkg::QUAL_W + 1;
    localparam int PROD_W = caps_pkg::QUAL_W + caps_pkg::RATE_W + 2;
    localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) <<< (caps_pkg::BLEND_SHIFT - 1);

    logic signed [DIFF_W-1:0]           diff;
    logic signed [caps_pkg::RATE_W:0]   weight_s;
    logic signed [PROD_W-1:0]           prod_next;
    logic signed [PROD_W-1:0]           prod_reg;
    logic [caps_pkg::QUAL_W-1:0]        old_reg;
    logic                               valid1_reg;
    logic signed [PROD_W-1:0]           rounded;
    logic signed [PROD_W-1:0]           scaled;
    logic [caps_pkg::QUAL_W-1:0]        value_next;
    logic [caps_pkg::QUAL_W-1:0]        value_reg;
    logic                               valid2_reg;

    assign diff      = $signed({1'b0, req.new_value}) - $signed({1'b0, req.old_value});
    assign weight_s  = $signed({1'b0, req.weight});
    assign prod_next = weight_s * diff;

    assign rounded    = prod_reg + ROUND;
    assign scaled     = rounded >>> caps_pkg::BLEND_SHIFT;
    assign value_next = old_reg + scaled[caps_pkg::QUAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= req.valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        old_reg   <= req.old_value;
        value_reg <= value_next;
    end

    assign rsp.valid = valid2_reg;
    assign rsp.value = value_reg;

endmodule

// ----- tb/tb_crossover_adaptive_pursuit_selector_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adaptive-pursuit selector testbench
// Drives select and reward update items through the valid/ready channels and
// checks each result against a cycle-free model of the operator probabilities,
// qualities and use counts, or against the result typed in a directed row. A
// short directed list walks warm-up, the first pursuit steps and the saturating
// reward cases. Random phases follow, each with its own register setting and
// a full drain of pending results; all but one idle at random, one has a long hold-off.
// ----------------------------------------------------------------------------
module tb_crossover_adaptive_pursuit_selector_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 100;
    localparam int NUM_PHASES  = 5;
    localparam int N_OPS       = caps_pkg::NUM_OPERATORS;

    typedef struct {
        caps_pkg::item_t   stim;
        bit                typed;
        caps_pkg::result_t want;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_write;
    logic [caps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [caps_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            item_valid;
    logic                            item_ready;
    caps_pkg::item_t                 item;
    logic                            result_valid;
    logic                            result_ready;
    caps_pkg::result_t               result;

    logic [caps_pkg::PROB_W-1:0]  op_prob     [N_OPS];
    logic [caps_pkg::QUAL_W-1:0]  op_quality  [N_OPS];
    logic [caps_pkg::COUNT_W-1:0] op_uses     [N_OPS];
    logic [caps_pkg::COUNT_W-1:0] op_credited [N_OPS];
    logic [caps_pkg::RATE_W-1:0]  alpha_reg;
    logic [caps_pkg::RATE_W-1:0]  beta_reg;
    logic [caps_pkg::FLOOR_W-1:0] floor_reg;

    caps_pkg::result_t predicted_outcomes[$];
    int      errors = 0;
    int      cycles = 0;
    int      hold_left = 0;
    bit      gaps_on = 1'b1;
    bit      hold_req = 1'b0;

    crossover_adaptive_pursuit_selector_top i_dut (.*);

    always #5 clk = ~clk;

    function automatic logic [63:0] mix_q16(input logic [63:0] old_v, input logic [63:0] new_v,
                                            input logic [63:0] w);
        return ((64'd65536 - w) * old_v + w * new_v + 64'd32768) >> 16;
    endfunction

    function automatic logic [1:0] leading_operator();
        int b;
        int i;
        b = 0;
        for (i = 1; i < N_OPS; i++)
            if (op_quality[b] < op_quality[i])
                b = i;
        return 2'(b);
    endfunction

    function automatic logic [caps_pkg::REWARD_W-1:0] makespan_gain(input caps_pkg::item_t it);
        logic [caps_pkg::SUM_W-1:0] psum;
        logic [caps_pkg::SUM_W-1:0] csum;
        logic [63:0]                ratio;
        psum = {1'b0, it.parent_a_makespan} + {1'b0, it.parent_b_makespan};
        csum = {1'b0, it.child_a_makespan} + {1'b0, it.child_b_makespan};
        if (csum == '0)
            return caps_pkg::REWARD_MAX;
        ratio = {15'b0, psum, 16'b0} / {31'b0, csum};
        return (ratio > 64'(caps_pkg::REWARD_MAX)) ? caps_pkg::REWARD_MAX
                                                    : ratio[caps_pkg::REWARD_W-1:0];
    endfunction

    function automatic void credit_operator(input int i, input logic [63:0] reward,
                                            input logic [63:0] alpha);
        op_credited[i] = op_uses[i];
        op_quality[i]  = caps_pkg::QUAL_W'(mix_q16(64'(op_quality[i]), reward, alpha));
    endfunction

    function automatic caps_pkg::result_t selector_step(input caps_pkg::item_t it);
        caps_pkg::result_t r;
        logic [63:0]       alpha;
        logic [63:0]       beta;
        logic [63:0]       pmin;
        logic [63:0]       pmax;
        logic [63:0]       taken;
        logic [63:0]       reward;
        logic [31:0]       cum;
        int                i;
        int                used;
        int                b;
        int                pick;
        bit                found;
        r = '0;
        if (it.func == caps_pkg::FUNC_SELECT)
        begin
            cum   = '0;
            pick  = N_OPS - 1;
            found = 1'b0;
            for (i = 0; i < N_OPS - 1; i++)
            begin
                cum = cum + 32'(op_prob[i]);
                if (!found && 32'(it.random_fraction) < cum)
                begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            op_uses[pick]     = op_uses[pick] + 1;
            r.chosen_operator = 2'(pick);
            r.was_selection   = 1'b1;
        end
        else
        begin
            alpha  = (alpha_reg > caps_pkg::ONE_Q16) ? 64'(caps_pkg::ONE_Q16) : 64'(alpha_reg);
            beta   = (beta_reg > caps_pkg::ONE_Q16) ? 64'(caps_pkg::ONE_Q16) : 64'(beta_reg);
            pmin   = (floor_reg > caps_pkg::FLOOR_MAX) ? 64'(caps_pkg::FLOOR_MAX)
                                                       : 64'(floor_reg);
            reward = 64'(makespan_gain(it));
            used   = 0;
            for (i = 0; i < N_OPS; i++)
                if (op_uses[i] != 0)
                    used++;
            if (used < N_OPS)
            begin
                for (i = 0; i < N_OPS; i++)
                begin
                    if (op_uses[i] == 1 && op_credited[i] != 1)
                    begin
                        credit_operator(i, reward, alpha);
                        op_prob[i] = '0;
                    end
                    else if (op_uses[i] == 0)
                    begin
                        op_prob[i] = caps_pkg::PROB_W'(65536 / (N_OPS - used));
                    end
                end
            end
            else
            begin
                taken = 64'(N_OPS - 1) * pmin;
                pmax  = (taken >= 64'd65536) ? 64'd0 : 64'd65536 - taken;
                for (i = 0; i < N_OPS; i++)
                    if (op_credited[i] < op_uses[i])
                        credit_operator(i, reward, alpha);
                b = leading_operator();
                for (i = 0; i < N_OPS; i++)
                    op_prob[i] = caps_pkg::PROB_W'(mix_q16(64'(op_prob[i]),
                                                           (i == b) ? pmax : pmin, beta));
            end
        end
        r.best_operator = leading_operator();
        return r;
    endfunction

    function automatic stim_row_t stim_row(input logic f, input logic [15:0] frac,
                                           input logic [31:0] pa, input logic [31:0] pb,
                                           input logic [31:0] ca, input logic [31:0] cb,
                                           input bit typed, input caps_pkg::result_t want);
        stim_row_t r;
        r.stim  = '{f, frac, pa, pb, ca, cb};
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic caps_pkg::item_t random_item(input logic f);
        caps_pkg::item_t it;
        logic [31:0]     boundary;
        int              mode;
        it.func            = f;
        it.random_fraction = 16'($urandom_range(65535));
        if ($urandom_range(3) == 0)
        begin
            boundary = 32'(op_prob[0]);
            if ($urandom_range(1) == 1)
                boundary = boundary + 32'(op_prob[1]);
            boundary = boundary + $urandom_range(2) - 1;
            it.random_fraction = (boundary > 32'd65535) ? 16'hFFFF : boundary[15:0];
        end
        it.parent_a_makespan = $urandom();
        it.parent_b_makespan = $urandom();
        it.child_a_makespan  = $urandom();
        it.child_b_makespan  = $urandom();
        mode = $urandom_range(9);
        if (mode >= 2 && mode <= 6)
        begin
            it.parent_a_makespan = $urandom_range(5000000, 1000);
            it.parent_b_makespan = $urandom_range(5000000, 1000);
            it.child_a_makespan  = $urandom_range(2 * it.parent_a_makespan,
                                                  it.parent_a_makespan / 2);
            it.child_b_makespan  = $urandom_range(2 * it.parent_b_makespan,
                                                  it.parent_b_makespan / 2);
        end
        else if (mode == 7)
        begin
            it.child_a_makespan = '0;
            it.child_b_makespan = '0;
        end
        else if (mode == 8)
        begin
            it.parent_a_makespan = ($urandom_range(1) == 1) ? '1 : '0;
            it.parent_b_makespan = ($urandom_range(1) == 1) ? '1 : '0;
            it.child_a_makespan  = ($urandom_range(1) == 1) ? '1 : '0;
            it.child_b_makespan  = ($urandom_range(1) == 1) ? '1 : '0;
        end
        else if (mode == 9)
        begin
            it.child_a_makespan = '0;
            it.child_b_makespan = $urandom_range(3);
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_item(input caps_pkg::item_t it, input bit typed,
                             input caps_pkg::result_t want);
        caps_pkg::result_t predicted;
        int                gap;
        gap = (gaps_on && $urandom_range(99) < 6) ? $urandom_range(8, 1) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        predicted = selector_step(it);
        predicted_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_outcomes.size() != 0);
    endtask

    task automatic set_rates(input logic [caps_pkg::RATE_W-1:0] q,
                             input logic [caps_pkg::RATE_W-1:0] p,
                             input logic [caps_pkg::FLOOR_W-1:0] f);
        cfg_write <= 1'b1;
        cfg_index <= caps_pkg::REG_QUALITY_RATE;
        cfg_data  <= q;
        @(posedge clk);
        cfg_index <= caps_pkg::REG_PURSUIT_RATE;
        cfg_data  <= p;
        @(posedge clk);
        cfg_index <= caps_pkg::REG_PROBABILITY_FLOOR;
        cfg_data  <= {2'b0, f};
        @(posedge clk);
        cfg_write <= 1'b0;
        alpha_reg = q;
        beta_reg  = p;
        floor_reg = f;
    endtask

    initial
    begin
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(99) < 6)
            begin
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        caps_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (predicted_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: result with none pending, expected nothing, got %h",
                         $time, result);
            end
            else
            begin
                want = predicted_outcomes.pop_front();
                check_field("chosen_operator", want.chosen_operator, result.chosen_operator);
                check_field("was_selection", want.was_selection, result.was_selection);
                check_field("best_operator", want.best_operator, result.best_operator);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[crossover_adaptive_pursuit_selector_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        bit        want_update;
        logic      f;
        int        ph;
        int        n;
        int        i;
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        alpha_reg  = caps_pkg::QRATE_RESET;
        beta_reg   = caps_pkg::PRATE_RESET;
        floor_reg  = caps_pkg::FLOOR_RESET;
        for (i = 0; i < N_OPS; i++)
        begin
            op_prob[i]     = caps_pkg::PROB_RESET;
            op_quality[i]  = caps_pkg::QUAL_RESET;
            op_uses[i]     = '0;
            op_credited[i] = '0;
        end

        // Warm-up, with one operator picked twice before its first reward.
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'd0, '0, '0, '0, '0,
                                1, '{2'd0, 1'b1, 2'd0}));
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'd100, '1, '1, '1, '1,
                                1, '{2'd0, 1'b1, 2'd0}));
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'hFFFF, '0, '0, '0, '0,
                                1, '{2'd2, 1'b1, 2'd0}));
        rows.push_back(stim_row(caps_pkg::FUNC_UPDATE, 16'hFFFF, '0, '0, '0, '0,
                                1, '{2'd0, 1'b0, 2'd2}));
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'd0, '0, '0, '0, '0,
                                1, '{2'd0, 1'b1, 2'd2}));
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'hFFFF, '0, '0, '0, '0,
                                1, '{2'd1, 1'b1, 2'd2}));
        // First pursuit step, then saturating and zero rewards.
        rows.push_back(stim_row(caps_pkg::FUNC_UPDATE, 16'd0, '1, '1, '1, '1,
                                1, '{2'd0, 1'b0, 2'd2}));
        rows.push_back(stim_row(caps_pkg::FUNC_UPDATE, 16'd0, '1, '1, 32'd1, '0, 0, '0));
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'd0, '0, '0, '0, '0, 0, '0));
        rows.push_back(stim_row(caps_pkg::FUNC_UPDATE, 16'd0, '0, '0, '1, '1, 0, '0));
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'hFFFF, '0, '0, '0, '0, 0, '0));
        rows.push_back(stim_row(caps_pkg::FUNC_UPDATE, 16'd0, 32'd1, '0, '0, 32'd1, 0, '0));
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'h8000, '1, '1, '1, '1, 0, '0));
        rows.push_back(stim_row(caps_pkg::FUNC_UPDATE, 16'hFFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                                32'h5555_5555, 32'hAAAA_AAAA, 0, '0));
        rows.push_back(stim_row(caps_pkg::FUNC_SELECT, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA,
                                32'hAAAA_AAAA, 32'h5555_5555, 0, '0));
        rows.push_back(stim_row(caps_pkg::FUNC_UPDATE, 16'hAAAA, '1, '1, '0, '0, 0, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[k])
            send_item(rows[k].stim, rows[k].typed, rows[k].want);
        want_update = 1'b0;

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain_results();
            repeat (4) @(posedge clk);
            case (ph)
                0: set_rates(17'd0, 17'd65536, 15'd21845);
                1: set_rates(17'd65536, 17'd0, 15'd0);
                2: set_rates(17'd131071, 17'd131071, 15'd32767);
                3: set_rates(17'($urandom_range(131071)), 17'($urandom_range(131071)),
                             15'($urandom_range(32767)));
                default: set_rates(caps_pkg::QRATE_RESET, caps_pkg::PRATE_RESET,
                                   caps_pkg::FLOOR_RESET);
            endcase
            gaps_on = (ph != 3);
            if (ph == 2)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain_results();
                f = want_update ? caps_pkg::FUNC_UPDATE : caps_pkg::FUNC_SELECT;
                if ($urandom_range(99) < 15)
                    f = 1'($urandom_range(1));
                send_item(random_item(f), 1'b0, '0);
                want_update = (f == caps_pkg::FUNC_SELECT);
            end
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[crossover_adaptive_pursuit_selector_top] OK");
        else
            $display("[crossover_adaptive_pursuit_selector_top] ERROR");
        $finish;
    end

endmodule
